// File: sv/dds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dds_pkg
// Shared types and constants for the door drive sequencer.
// ----------------------------------------------------------------------------
package dds_pkg;

    localparam int MAG_W     = 10;
    localparam int SPEED_W   = 11;
    localparam int STATE_W   = 4;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CREEP  = 1'b0,
        CFG_CRUISE = 1'b1
    } cfg_idx_t;

    typedef enum logic [STATE_W-1:0] {
        PH_INIT    = 4'd0,
        PH_UNKNOWN = 4'd1,
        PH_OPEN    = 4'd2,
        PH_ACC_POS = 4'd3,
        PH_POS     = 4'd4,
        PH_DEC_POS = 4'd5,
        PH_CLOSE   = 4'd6,
        PH_ACC_NEG = 4'd7,
        PH_NEG     = 4'd8,
        PH_DEC_NEG = 4'd9
    } phase_t;

    typedef struct packed {
        logic [MAG_W-1:0] creep;
        logic [MAG_W-1:0] cruise;
    } cfg_t;

    typedef struct packed {
        logic open_end;
        logic near_open;
        logic near_close;
        logic close_end;
    } switches_t;

    typedef struct packed {
        logic      direction_bit;
        switches_t sw;
    } scan_item_t;

    typedef struct packed {
        phase_t              phase;
        switches_t           last;
        logic signed [SPEED_W-1:0] speed;
    } drive_state_t;

endpackage

`default_nettype wire

// File: sv/dds_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dds_scan_if / dds_drive_if
// Valid/ready channels for scan ticks in and drive commands out.
// ----------------------------------------------------------------------------
interface dds_scan_if;
    logic valid;
    logic ready;
    logic direction_bit;
    logic switch_open_end;
    logic switch_near_open;
    logic switch_near_close;
    logic switch_close_end;

    modport source (
        output valid, direction_bit, switch_open_end, switch_near_open,
               switch_near_close, switch_close_end,
        input  ready
    );
    modport sink (
        input  valid, direction_bit, switch_open_end, switch_near_open,
               switch_near_close, switch_close_end,
        output ready
    );
endinterface

interface dds_drive_if;
    logic               valid;
    logic               ready;
    logic signed [10:0] speed_command;
    logic [3:0]         door_state;

    modport source (
        output valid, speed_command, door_state,
        input  ready
    );
    modport sink (
        input  valid, speed_command, door_state,
        output ready
    );
endinterface

`default_nettype wire

// File: sv/dds_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dds_cfg_regs
// Creep and cruise speed magnitude registers behind a plain write port.
// ----------------------------------------------------------------------------
module dds_cfg_regs
    import dds_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [MAG_W-1:0]     cfg_wdata,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CREEP:  cfg_next.creep  = cfg_wdata;
                CFG_CRUISE: cfg_next.cruise = cfg_wdata;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.creep  <= MAG_W'(100);
            cfg_reg.cruise <= MAG_W'(500);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: sv/dds_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dds_step
// Next-state logic of the drive sequencer for one scan tick.
// ----------------------------------------------------------------------------
module dds_step
    import dds_pkg::*;
(
    input  wire cfg_t         cfg,
    input  wire scan_item_t   item,
    input  wire drive_state_t cur,
    output drive_state_t      nxt
);

    logic signed [SPEED_W-1:0] pos_creep;
    logic signed [SPEED_W-1:0] neg_creep;
    logic signed [SPEED_W-1:0] pos_cruise;
    logic signed [SPEED_W-1:0] neg_cruise;
    logic                      d;
    switches_t                 trig;

    assign pos_creep  = $signed({1'b0, cfg.creep});
    assign neg_creep  = -pos_creep;
    assign pos_cruise = $signed({1'b0, cfg.cruise});
    assign neg_cruise = -pos_cruise;
    assign d          = item.direction_bit;
    assign trig       = item.sw ^ cur.last;

    always_comb
    begin
        nxt = cur;
        unique case (cur.phase)
            PH_INIT:
            begin
                nxt.speed = d ? pos_creep : neg_creep;
                nxt.phase = PH_UNKNOWN;
            end
            PH_UNKNOWN:
            begin
                if (d && trig.open_end)
                begin
                    nxt.last.open_end = item.sw.open_end;
                    nxt.speed         = '0;
                    nxt.phase         = PH_OPEN;
                end
                if (!d && trig.close_end)
                begin
                    nxt.last.close_end = item.sw.close_end;
                    nxt.speed          = '0;
                    nxt.phase          = PH_CLOSE;
                end
            end
            PH_OPEN:
            begin
                if (!d)
                begin
                    nxt.speed = pos_creep;
                    nxt.phase = PH_ACC_POS;
                end
            end
            PH_ACC_POS:
            begin
                if (trig.near_open)
                begin
                    nxt.last.near_open = item.sw.near_open;
                    nxt.speed          = pos_cruise;
                    nxt.phase          = PH_POS;
                end
                if (d)
                begin
                    nxt.speed = neg_creep;
                    nxt.phase = PH_DEC_NEG;
                end
            end
            PH_POS:
            begin
                if (trig.near_close)
                begin
                    nxt.last.near_close = item.sw.near_close;
                    nxt.speed           = pos_creep;
                    nxt.phase           = PH_DEC_POS;
                end
                if (d)
                begin
                    nxt.speed = neg_cruise;
                    nxt.phase = PH_NEG;
                end
            end
            PH_DEC_POS:
            begin
                if (trig.close_end)
                begin
                    nxt.last.close_end = item.sw.close_end;
                    nxt.speed          = '0;
                    nxt.phase          = PH_CLOSE;
                end
                if (d)
                begin
                    nxt.speed = neg_creep;
                    nxt.phase = PH_ACC_NEG;
                end
            end
            PH_CLOSE:
            begin
                if (d)
                begin
                    nxt.speed = neg_creep;
                    nxt.phase = PH_ACC_NEG;
                end
            end
            PH_ACC_NEG:
            begin
                if (trig.near_close)
                begin
                    nxt.last.near_close = item.sw.near_close;
                    nxt.speed           = neg_cruise;
                    nxt.phase           = PH_NEG;
                end
                if (!d)
                begin
                    nxt.speed = pos_creep;
                    nxt.phase = PH_DEC_POS;
                end
            end
            PH_NEG:
            begin
                if (trig.near_open)
                begin
                    nxt.last.near_open = item.sw.near_open;
                    nxt.speed          = neg_creep;
                    nxt.phase          = PH_DEC_NEG;
                end
                if (!d)
                begin
                    nxt.speed = pos_cruise;
                    nxt.phase = PH_POS;
                end
            end
            PH_DEC_NEG:
            begin
                if (trig.open_end)
                begin
                    nxt.last.open_end = item.sw.open_end;
                    nxt.speed         = '0;
                    nxt.phase         = PH_OPEN;
                end
                if (!d)
                begin
                    nxt.speed = pos_creep;
                    nxt.phase = PH_ACC_POS;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/door_drive_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// door_drive_sequencer_core
// Ten-state door drive sequencer: one speed command per scan tick.
//
//   channel   dir   protocol      payload
//   scan      in    valid/ready   direction_bit, four switch levels
//   drive     out   valid/ready   speed_command (s11), door_state (u4)
//   cfg       in    write only    creep_speed (0), cruise_speed (1)
//
// one request per cycle sustained while the drive side is ready; input
// register then result register, with the sequencer state updated as a
// request moves between them
// reset: state init, stored switch levels and speed zero, creep 100,
// cruise 500
// a stalled result holds while a further request waits in the input register
// ----------------------------------------------------------------------------
module door_drive_sequencer_core
    import dds_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    dds_scan_if.sink                  scan,
    dds_drive_if.source               drive,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [MAG_W-1:0]     cfg_wdata
);

    cfg_t         cfg;
    drive_state_t st_reg;
    drive_state_t st_next;
    scan_item_t   item_reg;
    scan_item_t   item_next;
    logic         item_valid_reg;
    logic         res_valid_reg;
    logic signed [SPEED_W-1:0] res_speed_reg;
    logic [STATE_W-1:0]        res_state_reg;
    logic         advance;
    logic         take;

    dds_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dds_step u_step (
        .cfg  (cfg),
        .item (item_reg),
        .cur  (st_reg),
        .nxt  (st_next)
    );

    assign advance    = item_valid_reg && (!res_valid_reg || drive.ready);
    assign scan.ready = !item_valid_reg || advance;
    assign take       = scan.valid && scan.ready;

    assign item_next.direction_bit = scan.direction_bit;
    assign item_next.sw.open_end   = scan.switch_open_end;
    assign item_next.sw.near_open  = scan.switch_near_open;
    assign item_next.sw.near_close = scan.switch_near_close;
    assign item_next.sw.close_end  = scan.switch_close_end;

    // control and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            st_reg.phase   <= PH_INIT;
            st_reg.last    <= '0;
            st_reg.speed   <= '0;
        end
        else
        begin
            if (scan.ready)
            begin
                item_valid_reg <= scan.valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end
            else if (drive.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
        if (advance)
        begin
            res_speed_reg <= st_next.speed;
            res_state_reg <= st_next.phase;
        end
    end

    assign drive.valid         = res_valid_reg;
    assign drive.speed_command = res_speed_reg;
    assign drive.door_state    = res_state_reg;

endmodule

`default_nettype wire

// File: sv/dds_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dds_checker
// Port-level checks on the drive command channel of the sequencer core.
// ----------------------------------------------------------------------------
module dds_checker
    import dds_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      drv_valid,
    input wire logic                      drv_ready,
    input wire logic signed [SPEED_W-1:0] drv_speed,
    input wire logic [STATE_W-1:0]        drv_state
);

    logic pos_phase;
    logic neg_phase;
    logic rest_phase;

    assign pos_phase  = (drv_state == PH_ACC_POS) || (drv_state == PH_POS) ||
                        (drv_state == PH_DEC_POS);
    assign neg_phase  = (drv_state == PH_ACC_NEG) || (drv_state == PH_NEG) ||
                        (drv_state == PH_DEC_NEG);
    assign rest_phase = (drv_state == PH_OPEN) || (drv_state == PH_CLOSE);

    // stalled request holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        drv_valid && !drv_ready |=> drv_valid && $stable(drv_speed) &&
                                    $stable(drv_state))
        else $error("drive request changed under stall");

    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        drv_valid |-> drv_state <= PH_DEC_NEG)
        else $error("door state code out of range");

    a_rest_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        drv_valid && rest_phase |-> drv_speed == '0)
        else $error("motor running at an end position");

    a_speed_sign: assert property (@(posedge clk) disable iff (!rst_n)
        drv_valid |-> (!pos_phase || !drv_speed[SPEED_W-1]) &&
                      (!neg_phase || drv_speed[SPEED_W-1] || drv_speed == '0))
        else $error("speed sign disagrees with travel direction");

endmodule

bind door_drive_sequencer_core dds_checker u_dds_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .drv_valid (drive.valid),
    .drv_ready (drive.ready),
    .drv_speed (drive.speed_command),
    .drv_state (drive.door_state)
);

`default_nettype wire

// File: dv/drive_cmd_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drive_cmd_check
// Watches the scan and drive channels and the register port of the door
// drive sequencer. It keeps its own copy of the sequencer state and speed
// settings, works out the drive command due for each accepted scan request
// and compares every accepted drive command with the oldest one outstanding.
// ----------------------------------------------------------------------------
module drive_cmd_check
    import dds_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    dds_scan_if                  scan,
    dds_drive_if                 drive,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MAG_W-1:0]     cfg_wdata,
    output int                   mismatches,
    output int                   cmds_pending
);

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic [STATE_W-1:0]        state;
    } drive_cmd_t;

    drive_cmd_t                pending_cmds[$];
    logic [MAG_W-1:0]          creep_mag;
    logic [MAG_W-1:0]          cruise_mag;
    phase_t                    door_phase;
    switches_t                 seen;
    logic signed [SPEED_W-1:0] door_speed;

    initial mismatches = 0;

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic go(input logic signed [SPEED_W-1:0] speed, input phase_t nxt);
        door_speed = speed;
        door_phase = nxt;
    endtask

    // later direction test overrides the switch test within one state
    task automatic advance_door(input logic d, input switches_t sw);
        logic signed [SPEED_W-1:0] creep;
        logic signed [SPEED_W-1:0] cruise;
        creep  = $signed({1'b0, creep_mag});
        cruise = $signed({1'b0, cruise_mag});
        case (door_phase)
            PH_INIT:
                go(d ? creep : -creep, PH_UNKNOWN);
            PH_UNKNOWN:
            begin
                if (d && sw.open_end != seen.open_end)
                begin
                    seen.open_end = sw.open_end;
                    go('0, PH_OPEN);
                end
                if (!d && sw.close_end != seen.close_end)
                begin
                    seen.close_end = sw.close_end;
                    go('0, PH_CLOSE);
                end
            end
            PH_OPEN:
                if (!d) go(creep, PH_ACC_POS);
            PH_ACC_POS:
            begin
                if (sw.near_open != seen.near_open)
                begin
                    seen.near_open = sw.near_open;
                    go(cruise, PH_POS);
                end
                if (d) go(-creep, PH_DEC_NEG);
            end
            PH_POS:
            begin
                if (sw.near_close != seen.near_close)
                begin
                    seen.near_close = sw.near_close;
                    go(creep, PH_DEC_POS);
                end
                if (d) go(-cruise, PH_NEG);
            end
            PH_DEC_POS:
            begin
                if (sw.close_end != seen.close_end)
                begin
                    seen.close_end = sw.close_end;
                    go('0, PH_CLOSE);
                end
                if (d) go(-creep, PH_ACC_NEG);
            end
            PH_CLOSE:
                if (d) go(-creep, PH_ACC_NEG);
            PH_ACC_NEG:
            begin
                if (sw.near_close != seen.near_close)
                begin
                    seen.near_close = sw.near_close;
                    go(-cruise, PH_NEG);
                end
                if (!d) go(creep, PH_DEC_POS);
            end
            PH_NEG:
            begin
                if (sw.near_open != seen.near_open)
                begin
                    seen.near_open = sw.near_open;
                    go(-creep, PH_DEC_NEG);
                end
                if (!d) go(cruise, PH_POS);
            end
            PH_DEC_NEG:
            begin
                if (sw.open_end != seen.open_end)
                begin
                    seen.open_end = sw.open_end;
                    go('0, PH_OPEN);
                end
                if (!d) go(creep, PH_ACC_POS);
            end
            default: ;
        endcase
        pending_cmds.push_back('{speed: door_speed, state: door_phase});
    endtask

    task automatic check_cmd();
        drive_cmd_t want;
        if (pending_cmds.size() == 0)
        begin
            report($sformatf("drive command with none outstanding: speed %0d state %0d",
                             $signed(drive.speed_command), drive.door_state));
            return;
        end
        want = pending_cmds.pop_front();
        if (drive.speed_command !== want.speed)
            report($sformatf("speed_command expected %0d got %0d",
                             want.speed, $signed(drive.speed_command)));
        if (drive.door_state !== want.state)
            report($sformatf("door_state expected %0d got %0d",
                             want.state, drive.door_state));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            creep_mag  = 10'd100;
            cruise_mag = 10'd500;
            door_phase = PH_INIT;
            seen       = '0;
            door_speed = '0;
            pending_cmds.delete();
            cmds_pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CREEP:  creep_mag  = cfg_wdata;
                    CFG_CRUISE: cruise_mag = cfg_wdata;
                    default: ;
                endcase
            end
            if (scan.valid && scan.ready)
                advance_door(scan.direction_bit,
                             '{open_end:   scan.switch_open_end,
                               near_open:  scan.switch_near_open,
                               near_close: scan.switch_near_close,
                               close_end:  scan.switch_close_end});
            if (drive.valid && drive.ready)
                check_cmd();
            cmds_pending <= pending_cmds.size();
        end
    end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives scan requests into the door drive sequencer: a directed tour of
// every state and override, then random door travel with noise, over several
// creep and cruise settings. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb_top;
    import dds_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int LONG_HOLD   = 200;
    localparam int PHASE_ITEMS = 100;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MAG_W-1:0]     cfg_wdata;
    logic                 long_hold_req;
    int                   mismatches;
    int                   cmds_pending;
    int unsigned          cycle_count;
    int                   burst_left;
    int                   door_at;
    logic                 dir;
    logic [0:3]           lv;

    dds_scan_if  scan_ch();
    dds_drive_if drive_ch();

    door_drive_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .scan      (scan_ch.sink),
        .drive     (drive_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    drive_cmd_check cmd_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .scan         (scan_ch),
        .drive        (drive_ch),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .cmds_pending (cmds_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stall pattern plus one long hold-off on request
    initial
    begin : receiver
        int  mode;
        int  span;
        bit  long_done;
        long_done = 1'b0;
        drive_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (long_hold_req && !long_done)
            begin
                long_done = 1'b1;
                drive_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(1, 30);
            repeat (span)
            begin
                case (mode)
                    0:       drive_ch.ready <= 1'b1;
                    1:       drive_ch.ready <= 1'($urandom_range(0, 1));
                    2:       drive_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: drive_ch.ready <= 1'b0;
                endcase
                @(posedge clk);
            end
        end
    end

    task automatic offer(input logic d, input switches_t sw);
        int gap;
        scan_ch.valid             <= 1'b1;
        scan_ch.direction_bit     <= d;
        scan_ch.switch_open_end   <= sw.open_end;
        scan_ch.switch_near_open  <= sw.near_open;
        scan_ch.switch_near_close <= sw.near_close;
        scan_ch.switch_close_end  <= sw.close_end;
        do @(posedge clk); while (!scan_ch.ready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 10);
            scan_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        scan_ch.valid <= 1'b0;
        do @(posedge clk); while (cmds_pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_speeds(input logic [MAG_W-1:0] creep, input logic [MAG_W-1:0] cruise);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CREEP;
        cfg_wdata <= creep;
        @(posedge clk);
        cfg_index <= CFG_CRUISE;
        cfg_wdata <= cruise;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // door travel: at times the next switch in the direction of motion changes level; some requests are random noise
    task automatic random_request();
        if ($urandom_range(0, 9) == 0)
            dir = ~dir;
        if ($urandom_range(0, 7) == 0)
            offer(1'($urandom_range(0, 1)), switches_t'(4'($urandom_range(0, 15))));
        else
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                if (!dir && door_at < 3)
                begin
                    door_at++;
                    lv[door_at] = ~lv[door_at];
                end
                else if (dir && door_at > 0)
                begin
                    door_at--;
                    lv[door_at] = ~lv[door_at];
                end
            end
            offer(dir, switches_t'(lv));
        end
    endtask

    task automatic random_phase();
        repeat (PHASE_ITEMS) random_request();
    endtask

    initial
    begin : stimulus
        logic [4:0] tour [26];
        tour = '{5'b1_0000, 5'b0_0000, 5'b1_0001, 5'b1_1111, 5'b1_1111,
                 5'b0_1111, 5'b1_1111, 5'b0_1111, 5'b0_1011, 5'b0_1001,
                 5'b0_1011, 5'b0_0011, 5'b0_0011, 5'b1_0011, 5'b1_0001,
                 5'b0_0101, 5'b1_0111, 5'b1_0011, 5'b1_0011, 5'b0_0011,
                 5'b1_0011, 5'b0_1011, 5'b0_1111, 5'b0_1101, 5'b1_1100,
                 5'b0_1110};
        rst_n                     <= 1'b0;
        cfg_we                    <= 1'b0;
        cfg_index                 <= CFG_CREEP;
        cfg_wdata                 <= '0;
        long_hold_req             <= 1'b0;
        scan_ch.valid             <= 1'b0;
        scan_ch.direction_bit     <= 1'b0;
        scan_ch.switch_open_end   <= 1'b0;
        scan_ch.switch_near_open  <= 1'b0;
        scan_ch.switch_near_close <= 1'b0;
        scan_ch.switch_close_end  <= 1'b0;
        burst_left = 0;
        door_at    = 0;
        dir        = 1'b0;
        lv         = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (tour[i])
            offer(tour[i][4], switches_t'(tour[i][3:0]));
        drain();

        set_speeds(10'd0, 10'd0);
        random_phase();
        drain();

        set_speeds(10'd890, 10'd890);
        long_hold_req <= 1'b1;
        random_phase();
        drain();

        set_speeds(10'($urandom_range(0, 890)), 10'($urandom_range(0, 890)));
        random_phase();
        drain();

        set_speeds(10'd890, 10'd0);
        random_phase();
        drain();

        if (mismatches == 0 && cmds_pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
sv/dds_pkg.sv
sv/dds_if.sv
sv/dds_cfg_regs.sv
sv/dds_step.sv
sv/door_drive_sequencer_core.sv
sv/dds_checker.sv
dv/drive_cmd_check.sv
dv/tb_top.sv
